FILE: hdl/csl_pkg.sv
package csl_pkg;

  // Field widths of the tick word and the configuration registers.
  localparam int unsigned VOLT_W  = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned TICK_W  = 17;

  // Saturation value of the tick counter.
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [INDEX_W-1:0] {
    CFG_NO_BATTERY  = 3'd0,
    CFG_GREEN       = 3'd1,
    CFG_BLINK       = 3'd2,
    CFG_BLINK_PER   = 3'd3,
    CFG_ERR_ON_PER  = 3'd4,
    CFG_ERR_OFF_PER = 3'd5
  } cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] BLINK_PER_RST   = 16'd500;
  localparam logic [CFG_W-1:0] ERR_ON_PER_RST  = 16'd250;
  localparam logic [CFG_W-1:0] ERR_OFF_PER_RST = 16'd250;

  // Current configuration as seen by the LED engine.
  typedef struct packed {
    logic [CFG_W-1:0] nobatt_limit;
    logic [CFG_W-1:0] green_threshold;
    logic [CFG_W-1:0] blink_threshold;
    logic [CFG_W-1:0] blink_period;
    logic [CFG_W-1:0] error_on_period;
    logic [CFG_W-1:0] error_off_period;
  } cfg_t;

  // One tick word.
  typedef struct packed {
    logic [VOLT_W-1:0] voltage;
    logic              top_slot;
    logic              error_active;
  } tick_t;

  // LED drive for one result word.
  typedef struct packed {
    logic red_on;
    logic green_on;
  } led_t;

endpackage

FILE: hdl/csl_in_if.sv
interface csl_in_if
  import csl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] voltage;
  logic              top_slot;
  logic              error_active;

  modport source (output valid, output voltage, output top_slot, output error_active,
                  input ready);
  modport sink   (input valid, input voltage, input top_slot, input error_active,
                  output ready);
endinterface

FILE: hdl/csl_out_if.sv
interface csl_out_if;
  logic valid;
  logic ready;
  logic red_on;
  logic green_on;

  modport source (output valid, output red_on, output green_on, input ready);
  modport sink   (input valid, input red_on, input green_on, output ready);
endinterface

FILE: hdl/csl_cfg_if.sv
interface csl_cfg_if
  import csl_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;
  logic [CFG_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/csl_cfg_regs.sv
module csl_cfg_regs
  import csl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [INDEX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]   wr_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index; unused indexes leave everything unchanged.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_NO_BATTERY:  cfg_nxt.nobatt_limit     = wr_data;
        CFG_GREEN:       cfg_nxt.green_threshold  = wr_data;
        CFG_BLINK:       cfg_nxt.blink_threshold  = wr_data;
        CFG_BLINK_PER:   cfg_nxt.blink_period     = wr_data;
        CFG_ERR_ON_PER:  cfg_nxt.error_on_period  = wr_data;
        CFG_ERR_OFF_PER: cfg_nxt.error_off_period = wr_data;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nobatt_limit     <= '0;
      cfg_r.green_threshold  <= '0;
      cfg_r.blink_threshold  <= '0;
      cfg_r.blink_period     <= BLINK_PER_RST;
      cfg_r.error_on_period  <= ERR_ON_PER_RST;
      cfg_r.error_off_period <= ERR_OFF_PER_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/csl_engine.sv
module csl_engine
  import csl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  tick_t tick,
  input  cfg_t  cfg,
  output led_t  led_nxt
);

  logic              green_sel_r, green_sel_nxt;
  logic              red_sel_r, red_sel_nxt;
  logic              green_lit_r, green_lit_nxt;
  logic              red_lit_r, red_lit_nxt;
  logic              blink_en_r, blink_en_nxt;
  logic              err_seen_r, err_seen_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic              want_blink;
  logic [TICK_W-1:0] ticks_inc;

  // Colour rules first, then the blink rules, all on one tick word.
  always_comb begin
    green_sel_nxt = green_sel_r;
    red_sel_nxt   = red_sel_r;
    green_lit_nxt = green_lit_r;
    red_lit_nxt   = red_lit_r;
    blink_en_nxt  = blink_en_r;
    err_seen_nxt  = err_seen_r;
    want_blink    = (tick.voltage > cfg.blink_threshold) && tick.top_slot;

    // Colour selection is frozen while an error is active; blink enable is cleared on entry to error.
    if (!tick.error_active) begin
      if (tick.voltage > cfg.nobatt_limit) begin
        green_sel_nxt = 1'b0;
        red_sel_nxt   = 1'b0;
        green_lit_nxt = 1'b0;
        red_lit_nxt   = 1'b0;
      end else if (tick.voltage < cfg.green_threshold) begin
        if (green_sel_r || !red_sel_r) begin
          green_sel_nxt = 1'b0;
          red_sel_nxt   = 1'b1;
          green_lit_nxt = 1'b0;
          red_lit_nxt   = 1'b1;
        end
      end else begin
        if (!green_sel_r || red_sel_r) begin
          green_sel_nxt = 1'b1;
          red_sel_nxt   = 1'b0;
          green_lit_nxt = 1'b1;
          red_lit_nxt   = 1'b0;
        end
      end
      blink_en_nxt = want_blink;
      if (!want_blink) begin
        green_lit_nxt = green_sel_nxt;
        red_lit_nxt   = red_sel_nxt;
      end
    end

    // Saturating tick count.
    ticks_inc = (ticks_r == TICK_MAX) ? ticks_r : ticks_r + 1'b1;
    ticks_nxt = ticks_inc;

    if (tick.error_active) begin
      if (!err_seen_r) begin
        // Entry to error darkens both LEDs.
        err_seen_nxt  = 1'b1;
        blink_en_nxt  = 1'b0;
        green_lit_nxt = 1'b0;
        red_lit_nxt   = 1'b0;
      end else if (red_lit_r) begin
        if (ticks_inc > {1'b0, cfg.error_on_period}) begin
          ticks_nxt   = '0;
          red_lit_nxt = 1'b0;
        end
      end else if (ticks_inc > {1'b0, cfg.error_off_period}) begin
        ticks_nxt   = '0;
        red_lit_nxt = 1'b1;
      end
    end else begin
      err_seen_nxt = 1'b0;
      if (blink_en_nxt && (ticks_inc > {1'b0, cfg.blink_period})) begin
        ticks_nxt     = '0;
        green_lit_nxt = green_sel_nxt && !green_lit_nxt;
        red_lit_nxt   = red_sel_nxt && !red_lit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_sel_r <= 1'b0;
      red_sel_r   <= 1'b0;
      green_lit_r <= 1'b0;
      red_lit_r   <= 1'b0;
      blink_en_r  <= 1'b0;
      err_seen_r  <= 1'b0;
      ticks_r     <= '0;
    end else if (step) begin
      green_sel_r <= green_sel_nxt;
      red_sel_r   <= red_sel_nxt;
      green_lit_r <= green_lit_nxt;
      red_lit_r   <= red_lit_nxt;
      blink_en_r  <= blink_en_nxt;
      err_seen_r  <= err_seen_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

  assign led_nxt.red_on   = red_lit_nxt;
  assign led_nxt.green_on = green_lit_nxt;

endmodule

FILE: hdl/charge_status_led_blinker_top.sv
// Charge status LED blinker. Each input word is one millisecond tick; each tick
// gives exactly one result word with the red and green LED drive (1 = lit).
// The block takes one word per clock cycle while the output is not stalled. An
// accepted word sits in the input register while the LED engine, whose colour
// and blink state feeds back on itself every tick, works on it; when the output
// register can take it, the result is loaded into the output register and waits
// there to be taken. An output register lets a new word enter while the last
// result waits to be taken; the input stalls only when both registers are full.
// The six configuration registers (indexes 0 to 5) are written through the
// cfg channel, which is always ready; write them only while the block is idle.
// Reset values: thresholds 0, blink period 500, error on and off periods 250.
module charge_status_led_blinker_top
  import csl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  csl_in_if.sink    in_ch,
  csl_out_if.source out_ch,
  csl_cfg_if.sink   cfg_ch
);

  tick_t tick_r;
  logic  tick_vld_r;
  led_t  led_r;
  logic  out_vld_r;
  led_t  led_nxt;
  cfg_t  cfg;
  logic  out_free;
  logic  step;
  logic  in_take;

  // Handshake: the engine steps when a word is held and the output can take it.
  assign out_free = !out_vld_r || out_ch.ready;
  assign step     = tick_vld_r && out_free;
  assign in_ch.ready = !tick_vld_r || step;
  assign in_take  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  csl_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  csl_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .tick    (tick_r),
    .cfg     (cfg),
    .led_nxt (led_nxt)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      tick_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tick_r.voltage      <= in_ch.voltage;
      tick_r.top_slot     <= in_ch.top_slot;
      tick_r.error_active <= in_ch.error_active;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      led_r <= led_nxt;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.red_on   = led_r.red_on;
  assign out_ch.green_on = led_r.green_on;

endmodule

FILE: hdl/csl_checker.sv
module csl_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_red_on,
  input logic out_green_on,
  input logic cfg_ready
);

  // No result word is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // The input side stalls only while a result word waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty output");

  // Every accepted word is followed by a result word shown at the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("accepted word gave no result in time");

  // A stalled result word keeps its LED values.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_red_on) && $stable(out_green_on)))
    else $error("stalled result word changed");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind charge_status_led_blinker_top csl_checker u_csl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_red_on   (out_ch.red_on),
  .out_green_on (out_ch.green_on),
  .cfg_ready    (cfg_ch.ready)
);
